/* design/mexp_pkg.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, register indexes, reset values, controller states,
// datapath commands and the status bundle of the exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  // Width of every operand port.
  localparam int unsigned DATA_W = 64;

  // Default operand width inside the block.
  localparam int unsigned OPERAND_WIDTH_DEF = 64;

  // Configuration port index width and register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS        = 2'd1;

  // Register values after reset.
  localparam logic [DATA_W-1:0] BASE_RESET = 64'd2;
  localparam logic [DATA_W-1:0] MOD_RESET  = 64'd1;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_REDUCE,
    S_RED_WB,
    S_CHECK,
    S_MUL,
    S_MUL_WB,
    S_SQR_CHECK,
    S_SQR,
    S_SQR_WB,
    S_FINISH
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STEP_RED,
    CMD_STEP_MUL,
    CMD_WB_BASE,
    CMD_MUL_START,
    CMD_SQR_START,
    CMD_WB_ACC,
    CMD_SHIFT,
    CMD_DONE
  } cmd_e;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic exp_bit;
    logic exp_zero;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/mexp_dp.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Holds the configuration registers, the exponent shifter, the running
// result and base, and one bit-serial modular multiply step unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_dp #(
  parameter int unsigned OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mexp_pkg::DATA_W-1:0]     cfg_data_i,
  input  wire logic [mexp_pkg::DATA_W-1:0]     exponent_i,
  input  wire mexp_pkg::cmd_e                  cmd_i,
  output mexp_pkg::dp_status_t                 status_o,
  output logic      [mexp_pkg::DATA_W-1:0]     result_o
);

  import mexp_pkg::*;

  localparam int unsigned W = OPERAND_WIDTH;

  logic [W-1:0] base_q, mod_q;
  logic [W-1:0] exp_q, acc_q, b_q;
  logic [W-1:0] mul_a_q, mul_acc_q, mul_sh_q;
  logic [W-1:0] result_q;

  logic [W:0]   mod_ext;
  logic [W:0]   dbl_sum, add_sum;
  logic [W-1:0] dbl_res, addend, step_res, one_mod;

  // Configuration registers; user must write only while idle (unchecked).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= W'(BASE_RESET);
      mod_q  <= W'(MOD_RESET);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_GENERATOR_BASE) begin
        base_q <= cfg_data_i[W-1:0];
      end else if (cfg_index_i == REG_MODULUS) begin
        mod_q <= cfg_data_i[W-1:0];
      end
    end
  end

  // One step of double-and-add modulo the modulus. In reduce mode the
  // addend is the base bit, so shifting the base in bit by bit reduces it.
  always_comb begin
    mod_ext = {1'b0, mod_q};
    dbl_sum = {mul_acc_q, 1'b0};
    dbl_res = (dbl_sum >= mod_ext) ? W'(dbl_sum - mod_ext) : dbl_sum[W-1:0];
    if (!mul_sh_q[W-1]) begin
      addend = '0;
    end else if (cmd_i == CMD_STEP_RED) begin
      addend = W'(1);
    end else begin
      addend = mul_a_q;
    end
    add_sum  = {1'b0, dbl_res} + {1'b0, addend};
    step_res = (add_sum >= mod_ext) ? W'(add_sum - mod_ext) : add_sum[W-1:0];
    one_mod  = (mod_q == W'(1)) ? '0 : W'(1);
  end

  // Working registers, driven by the controller's command.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_NONE: begin
      end
      CMD_LOAD: begin
        exp_q     <= exponent_i[W-1:0];
        acc_q     <= one_mod;
        mul_acc_q <= '0;
        mul_sh_q  <= base_q;
      end
      CMD_STEP_RED, CMD_STEP_MUL: begin
        mul_acc_q <= step_res;
        mul_sh_q  <= {mul_sh_q[W-2:0], 1'b0};
      end
      CMD_WB_BASE: begin
        b_q <= mul_acc_q;
      end
      CMD_MUL_START: begin
        mul_acc_q <= '0;
        mul_a_q   <= acc_q;
        mul_sh_q  <= b_q;
      end
      CMD_SQR_START: begin
        mul_acc_q <= '0;
        mul_a_q   <= b_q;
        mul_sh_q  <= b_q;
      end
      CMD_WB_ACC: begin
        acc_q <= mul_acc_q;
        exp_q <= exp_q >> 1;
      end
      CMD_SHIFT: begin
        exp_q <= exp_q >> 1;
      end
      CMD_DONE: begin
        result_q <= (mod_q == '0) ? '0 : acc_q;
      end
    endcase
  end

  // Status and result.
  assign status_o.exp_bit  = exp_q[0];
  assign status_o.exp_zero = (exp_q == '0);
  assign result_o          = DATA_W'(result_q);

`ifndef NO_ASSERTIONS
  // A step keeps the partial product below a nonzero modulus.
  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i == CMD_STEP_RED || cmd_i == CMD_STEP_MUL) && mod_q != '0 &&
     mul_acc_q < mod_q) |-> step_res < mod_q)
    else $error("modular step left the range of the modulus");

  // A zero modulus always yields a zero result.
  a_zero_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_DONE && mod_q == '0) |=> result_q == '0)
    else $error("nonzero result for a zero modulus");
`endif

endmodule

`default_nettype wire

/* design/mexp_ctrl.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences base reduction, multiply and square passes over the exponent
// bits, counts the bit-serial steps, and handles both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_ctrl #(
  parameter int unsigned OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire mexp_pkg::dp_status_t status_i,
  output mexp_pkg::cmd_e            cmd_o
);

  import mexp_pkg::*;

  localparam int unsigned CntW = $clog2(OPERAND_WIDTH);

  ctl_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            stepping, cnt_last, slot_free;

  assign stepping  = (state_q == S_REDUCE) || (state_q == S_MUL) || (state_q == S_SQR);
  assign cnt_last  = (cnt_q == CntW'(OPERAND_WIDTH - 1));
  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state and step counter.
  always_comb begin
    state_d = state_q;
    cnt_d   = (stepping && !cnt_last) ? cnt_q + CntW'(1) : '0;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_REDUCE;
      S_REDUCE:    if (cnt_last) state_d = S_RED_WB;
      S_RED_WB:    state_d = S_CHECK;
      S_CHECK: begin
        if (status_i.exp_zero) begin
          state_d = S_FINISH;
        end else if (status_i.exp_bit) begin
          state_d = S_MUL;
        end else begin
          state_d = S_SQR_CHECK;
        end
      end
      S_MUL:       if (cnt_last) state_d = S_MUL_WB;
      S_MUL_WB:    state_d = S_SQR_CHECK;
      S_SQR_CHECK: state_d = status_i.exp_zero ? S_FINISH : S_SQR;
      S_SQR:       if (cnt_last) state_d = S_SQR_WB;
      S_SQR_WB:    state_d = S_CHECK;
      S_FINISH:    if (slot_free) state_d = S_IDLE;
    endcase
  end

  // Datapath commands per state.
  always_comb begin
    cmd_o = CMD_NONE;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) cmd_o = CMD_LOAD;
      S_REDUCE:    cmd_o = CMD_STEP_RED;
      S_RED_WB:    cmd_o = CMD_WB_BASE;
      S_CHECK: begin
        if (status_i.exp_zero) begin
          cmd_o = CMD_NONE;
        end else if (status_i.exp_bit) begin
          cmd_o = CMD_MUL_START;
        end else begin
          cmd_o = CMD_SHIFT;
        end
      end
      S_MUL:       cmd_o = CMD_STEP_MUL;
      S_MUL_WB:    cmd_o = CMD_WB_ACC;
      S_SQR_CHECK: cmd_o = status_i.exp_zero ? CMD_NONE : CMD_SQR_START;
      S_SQR:       cmd_o = CMD_STEP_MUL;
      S_SQR_WB:    cmd_o = CMD_WB_BASE;
      S_FINISH:    if (slot_free) cmd_o = CMD_DONE;
    endcase
  end

  // Output beat holds until taken.
  assign out_valid_d = (cmd_o == CMD_DONE) ? 1'b1 : (out_valid_q && out_stall_i);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted beat starts the base reduction.
  a_accept_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_REDUCE)
    else $error("accepted beat did not start base reduction");

  // The step counter rests at zero outside the stepping states.
  a_cnt_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stepping |-> cnt_q == '0)
    else $error("step counter not cleared outside a pass");

  // A new result never overwrites one still waiting at the output.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> cmd_o != CMD_DONE)
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

/* design/modular_exponentiation_64.sv */
// ----------------------------------------------------------------------------
// Modular exponentiation, 64-bit
// Computes generator_base to the power of each exponent beat, modulo the
// configured modulus, by right-to-left binary square-and-multiply.
// ----------------------------------------------------------------------------
// Each exponent beat yields one result beat. The base is first reduced by
// shifting it into one bit-serial modular multiply unit, and every multiply
// or square then runs that same unit once per operand bit, one double-and-add
// per cycle. Per exponent bit up to the highest set bit the block does a
// square, preceded by a multiply when the bit is set; the square after the
// highest set bit is skipped. An exponent of zero goes to the finish
// straight after the reduction. One beat is worked at a time; the next beat
// is taken once the result sits in the output register, even while that
// result is stalled. A zero modulus gives a zero result. Configuration
// writes must happen while idle.
`default_nettype none

module modular_exponentiation_64 #(
  parameter int unsigned OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mexp_pkg::DATA_W-1:0]    cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [mexp_pkg::DATA_W-1:0]    exponent_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [mexp_pkg::DATA_W-1:0]    power_result_o
);

  import mexp_pkg::*;

  cmd_e       cmd;
  dp_status_t status;

  // Sequencer.
  mexp_ctrl #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  mexp_dp #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .exponent_i (exponent_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .result_o   (power_result_o)
  );

endmodule

`default_nettype wire
